### hw/rtl/haversine_great_circle_distance_core_assert.svh
// assertion macros shared by the haversine distance checker
// no other dependencies
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_ASSERT_SVH

// same-cycle implication
`define HGCD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hgcd assertion failed");

// next-cycle implication
`define HGCD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hgcd assertion failed");

`endif

### hw/rtl/hgcd_pkg.sv
// shared types, constants and the arctangent table for the haversine core
// no dependencies
package hgcd_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int SQRT_STEPS   = 31;
  localparam int NUM_STAGES   = 2 * CORDIC_STEPS + SQRT_STEPS + 9;

  localparam logic [23:0] RADIUS_RESET = 24'd6371000;
  localparam logic [33:0] CORDIC_START = 34'd652032874;
  localparam logic [33:0] PI_Q32       = 34'd13493037705;
  localparam logic [30:0] Q_ONE        = 31'h4000_0000;

  localparam logic [29:0] ATAN_BAM [32] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41721, 30'd20861,
    30'd10430, 30'd5215, 30'd2608, 30'd1304, 30'd652, 30'd326, 30'd163,
    30'd81, 30'd41, 30'd20, 30'd10, 30'd5, 30'd3, 30'd1, 30'd1, 30'd0
  };

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
  } cordic_vec_t;

  typedef struct packed {
    logic [61:0] v;
    logic [32:0] rem;
    logic [30:0] root;
  } sqrt_t;

  function automatic logic signed [33:0] atan_bam(input logic [4:0] k);
    return $signed({4'b0000, ATAN_BAM[k]});
  endfunction

endpackage

### hw/rtl/haversine_great_circle_distance_core.sv
// throughput one word per cycle, unless the output word stalls on out_ready:
// every cordic step and sqrt digit is its own cell
// the whole pipeline stalls only while the output word waits on out_ready
// synchronous reset clears the valid chain and loads the radius with 6371000 m
// depends on hgcd_pkg, hgcd_cordic_cell, hgcd_sqrt_cell
module haversine_great_circle_distance_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] first_latitude,
  input  logic signed [31:0] first_longitude,
  input  logic signed [31:0] second_latitude,
  input  logic signed [31:0] second_longitude,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [25:0]        distance_m,
  input  logic               cfg_wr_en,
  input  logic [23:0]        cfg_wr_data
);
  import hgcd_pkg::*;

  logic [23:0]           earth_radius_m;
  logic [NUM_STAGES-1:0] vld;
  logic                  advance;

  // fold an angle into [-90, 90] degrees, flag a half-turn flip
  function automatic cordic_vec_t fold(input logic [31:0] ang, output logic flip);
    logic signed [33:0] z;
    cordic_vec_t        v;
    z    = $signed({{2{ang[31]}}, ang});
    flip = 1'b0;
    if (z > 34'sh0_4000_0000) begin
      z    = z - 34'sh0_8000_0000;
      flip = 1'b1;
    end else if (z < -34'sh0_4000_0000) begin
      z    = z + 34'sh0_8000_0000;
      flip = 1'b1;
    end
    v.x = $signed(CORDIC_START);
    v.y = '0;
    v.z = z;
    return v;
  endfunction

  assign advance   = !vld[NUM_STAGES-1] || out_ready;
  assign in_ready  = advance;
  assign out_valid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      earth_radius_m <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      earth_radius_m <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[NUM_STAGES-2:0], in_valid};
    end
  end

  // input stage: four rotation lanes, lat1, lat2, half dlat, half dlon
  cordic_vec_t rot [4][CORDIC_STEPS+1];
  cordic_vec_t pre_v [4];
  logic        pre_f [4];
  logic [31:0] dlat, dlon;
  logic                    pre_neg;
  logic [CORDIC_STEPS-1:0] neg_sr;

  always_comb begin
    dlat     = second_latitude - first_latitude;
    dlon     = second_longitude - first_longitude;
    pre_v[0] = fold(first_latitude, pre_f[0]);
    pre_v[1] = fold(second_latitude, pre_f[1]);
    pre_v[2] = fold({1'b0, dlat[31:1]}, pre_f[2]);
    pre_v[3] = fold({1'b0, dlon[31:1]}, pre_f[3]);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rot[0][0] <= pre_v[0];
      rot[1][0] <= pre_v[1];
      rot[2][0] <= pre_v[2];
      rot[3][0] <= pre_v[3];
      pre_neg <= pre_f[0] ^ pre_f[1];
      neg_sr  <= {neg_sr[CORDIC_STEPS-2:0], pre_neg};
    end
  end

  for (genvar l = 0; l < 4; l++) begin : g_rot_lane
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot_cell
      hgcd_cordic_cell u_cell (
        .clk       (clk),
        .en        (advance),
        .vectoring (1'b0),
        .shift     (5'(i)),
        .din       (rot[l][i]),
        .dout      (rot[l][i+1])
      );
    end
  end

  // products of the trig terms
  logic signed [31:0] c1, c2, slat, slon;
  logic signed [63:0] hl_p, hn_p, cc_p, cc_n;
  logic               cc_neg;
  logic signed [33:0] h_lat, h_lon, cc, h_lat3;
  logic signed [63:0] cross_p;
  logic signed [63:0] a_sum;
  logic [30:0]        a_q;

  always_comb begin
    c1   = rot[0][CORDIC_STEPS].x[31:0];
    c2   = rot[1][CORDIC_STEPS].x[31:0];
    slat = rot[2][CORDIC_STEPS].y[31:0];
    slon = rot[3][CORDIC_STEPS].y[31:0];
    cc_n = cc_neg ? -cc_p : cc_p;
    a_sum = 64'(h_lat3) + (cross_p >>> 30);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      hl_p    <= slat * slat;
      hn_p    <= slon * slon;
      cc_p    <= c1 * c2;
      cc_neg  <= neg_sr[CORDIC_STEPS-1];
      h_lat   <= 34'(hl_p >>> 30);
      h_lon   <= 34'(hn_p >>> 30);
      cc      <= 34'(cc_n >>> 30);
      cross_p <= $signed(cc[31:0]) * $signed(h_lon[31:0]);
      h_lat3  <= h_lat;
      if (a_sum < 0) begin
        a_q <= '0;
      end else if (a_sum > 64'(Q_ONE)) begin
        a_q <= Q_ONE;
      end else begin
        a_q <= a_sum[30:0];
      end
    end
  end

  // square roots of a and 1-a, one digit a cell
  sqrt_t sq [2][SQRT_STEPS+1];
  logic [30:0] one_minus_a;

  always_comb begin
    one_minus_a     = Q_ONE - a_q;
    sq[0][0].v      = {1'b0, a_q, 30'b0};
    sq[0][0].rem    = '0;
    sq[0][0].root   = '0;
    sq[1][0].v      = {1'b0, one_minus_a, 30'b0};
    sq[1][0].rem    = '0;
    sq[1][0].root   = '0;
  end

  for (genvar l = 0; l < 2; l++) begin : g_sq_lane
    for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq_cell
      hgcd_sqrt_cell u_cell (
        .clk  (clk),
        .en   (advance),
        .din  (sq[l][i]),
        .dout (sq[l][i+1])
      );
    end
  end

  // vectoring chain gives atan2(sqrt(a), sqrt(1-a))
  cordic_vec_t vec [CORDIC_STEPS+1];

  always_comb begin
    vec[0].x = $signed({3'b000, sq[1][SQRT_STEPS].root});
    vec[0].y = $signed({3'b000, sq[0][SQRT_STEPS].root});
    vec[0].z = '0;
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_vec_cell
    hgcd_cordic_cell u_cell (
      .clk       (clk),
      .en        (advance),
      .vectoring (1'b1),
      .shift     (5'(i)),
      .din       (vec[i]),
      .dout      (vec[i+1])
    );
  end

  // scale by radius and pi, round to meters
  logic signed [33:0] zf;
  logic [30:0]        zc;
  logic [54:0]        t;
  logic [61:0]        thp;
  logic [60:0]        tlp;
  logic [63:0]        acc;

  always_comb begin
    zf  = vec[CORDIC_STEPS].z;
    acc = 64'(thp) + 64'(tlp >> 27) + 64'h4_0000_0000;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (zf[33]) begin
        zc <= '0;
      end else if (zf > $signed({3'b000, Q_ONE})) begin
        zc <= Q_ONE;
      end else begin
        zc <= zf[30:0];
      end
      t          <= 55'(earth_radius_m) * 55'(zc);
      thp        <= 62'(t[54:27]) * 62'(PI_Q32);
      tlp        <= 61'(t[26:0]) * 61'(PI_Q32);
      distance_m <= acc[60:35];
    end
  end

endmodule

### hw/rtl/hgcd_cordic_cell.sv
// one cordic micro-rotation with its output register
// depends on hgcd_pkg
module hgcd_cordic_cell (
  input  logic                clk,
  input  logic                en,
  input  logic                vectoring,
  input  logic [4:0]          shift,
  input  hgcd_pkg::cordic_vec_t din,
  output hgcd_pkg::cordic_vec_t dout
);
  import hgcd_pkg::*;

  logic signed [33:0] xi, yi, zi, dx, dy, ang;
  logic               dir;

  always_comb begin
    xi  = din.x;
    yi  = din.y;
    zi  = din.z;
    dx  = yi >>> shift;
    dy  = xi >>> shift;
    ang = atan_bam(shift);
    // rotation steers on z, vectoring drives y toward zero
    dir = vectoring ? yi[33] : !zi[33];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (dir) begin
        dout.x <= xi - dx;
        dout.y <= yi + dy;
        dout.z <= zi - ang;
      end else begin
        dout.x <= xi + dx;
        dout.y <= yi - dy;
        dout.z <= zi + ang;
      end
    end
  end

endmodule

### hw/rtl/hgcd_sqrt_cell.sv
// one digit of a restoring integer square root, registered
// depends on hgcd_pkg
module hgcd_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  hgcd_pkg::sqrt_t din,
  output hgcd_pkg::sqrt_t dout
);
  import hgcd_pkg::*;

  logic [34:0] rem4, trial;
  logic        fit;

  always_comb begin
    rem4  = {din.rem, din.v[61:60]};
    trial = {2'b00, din.root, 2'b01};
    fit   = rem4 >= trial;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout.v    <= {din.v[59:0], 2'b00};
      dout.rem  <= fit ? 33'(rem4 - trial) : rem4[32:0];
      dout.root <= {din.root[29:0], fit};
    end
  end

endmodule

### hw/rtl/hgcd_checker.sv
// port-level checks for the haversine distance core, bound to the top level
// depends on haversine_great_circle_distance_core_assert.svh
`include "haversine_great_circle_distance_core_assert.svh"

module hgcd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [25:0] distance_m
);

  // a stalled result word holds
  `HGCD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(distance_m))
  // an empty output slot never stalls the input
  `HGCD_ASSERT_IMP(a_no_stall, clk, rst, !out_valid, in_ready)
  // distance stays within half the largest circumference
  `HGCD_ASSERT_IMP(a_range, clk, rst, out_valid, distance_m <= 26'd52707179)
  // nothing comes out right after reset
  `HGCD_ASSERT_IMP(a_rst_empty, clk, rst, $past(rst), !out_valid)

endmodule

bind haversine_great_circle_distance_core hgcd_checker u_hgcd_checker (.*);
